// File: design/spb_pkg.sv
// shared types and codes for the segmented pixel buffer
// no dependencies
package spb_pkg;

    // command codes carried on the input tuser
    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_LIST  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_SHOW  = 2'd3
    } func_t;

    localparam int unsigned RGB_W  = 24;
    localparam int unsigned WORD_W = 32;

    // one output word with its end-of-frame flag
    typedef struct packed {
        logic [WORD_W-1:0] strip_word;
        logic              frame_last;
    } out_word_t;

endpackage

// File: design/segmented_pixel_buffer_grb_top.sv
// top level of the segmented pixel buffer with grb strip output
// depends on spb_pkg, spb_scale, spb_store, spb_ofifo
//
// A frame buffer of SEGMENTS x SEG_PIXELS 24-bit rgb pixels. One word on
// the slave channel is one command (func on s_tuser). A pixel write goes
// through accept, scale and store write; a segment fill waits for the
// scaler and then makes one store write per cycle. Show and clear-and-show
// issue one store read per cycle, while read credit allows, through the
// single read port, so s_tready stays low after the command word until the
// last read of the frame has been issued; the first pixel word passes the
// store read register and the output queue, and with m_tready high the
// rest follow one per cycle. A two-word output queue with read credit
// sets the pace under backpressure. The next command is taken once the
// last read of a frame has been issued. After reset a clearing pass zeroes every store address while s_tready is low.
module segmented_pixel_buffer_grb_top #(
    parameter int unsigned SEGMENTS   = 4,
    parameter int unsigned SEG_PIXELS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // slave command channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata from bit 0: seg_index[7:0], pixel_index[15:8], rgb_color[39:16],
    // brightness[47:40], list_count[55:48], reverse_dir[56], zero fill
    input  logic [63:0] s_tdata,
    // s_tuser: func[1:0]
    input  logic [1:0]  s_tuser,
    // master pixel channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: strip_word[31:0]
    output logic [31:0] m_tdata,
    // m_tlast: frame_last
    output logic        m_tlast
);
    import spb_pkg::*;

    localparam int unsigned DEPTH = SEGMENTS * SEG_PIXELS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned PW    = (SEG_PIXELS > 1) ? $clog2(SEG_PIXELS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [PW-1:0] LAST_PIX  = PW'(SEG_PIXELS - 1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCALE,
        ST_WRITE,
        ST_FILL,
        ST_SHOW
    } state_t;

    // input fields
    func_t       in_func;
    logic [7:0]  in_seg;
    logic [7:0]  in_pix;
    logic [23:0] in_rgb;
    logic [7:0]  in_bright;
    logic [7:0]  in_count;
    logic        in_down;

    assign in_func   = func_t'(s_tuser);
    assign in_seg    = s_tdata[7:0];
    assign in_pix    = s_tdata[15:8];
    assign in_rgb    = s_tdata[39:16];
    assign in_bright = s_tdata[47:40];
    assign in_count  = s_tdata[55:48];
    assign in_down   = s_tdata[56];

    state_t        state_reg;
    logic [AW-1:0] ptr_reg;       // sweep pointer for init and show
    logic [AW-1:0] wr_addr_reg;   // single write address, or segment base for fill
    logic          do_write_reg;
    logic          zero_reg;      // show also clears
    logic [PW-1:0] fill_cnt_reg;
    logic          rd_pending_reg;
    logic          last_pending_reg;
    logic          zero_pending_reg;

    logic          accept;
    logic          dec_write;
    logic          dec_fill;
    logic [AW-1:0] dec_addr;
    logic [AW-1:0] seg_base;
    logic [7:0]    pix_sel;
    logic          seg_ok;
    logic          pix_ok;

    logic [RGB_W-1:0] scaled_rgb;
    logic             st_wr_en;
    logic [AW-1:0]    st_wr_addr;
    logic [RGB_W-1:0] st_wr_data;
    logic             issue;
    logic [RGB_W-1:0] rd_data;

    out_word_t  push_word;
    out_word_t  out_word;
    logic       pop;
    logic [1:0] q_count;
    logic [1:0] occupancy;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // command decode at accept time
    always_comb begin
        seg_ok    = (in_seg < 8'(SEGMENTS));
        pix_ok    = (in_pix < 8'(SEG_PIXELS));
        seg_base  = AW'(in_seg) * AW'(SEG_PIXELS);
        pix_sel   = in_pix;
        dec_write = 1'b0;
        dec_fill  = 1'b0;
        unique case (in_func) inside
            FUNC_WRITE: begin
                dec_write = seg_ok && pix_ok;
            end
            FUNC_LIST: begin
                if (seg_ok && (in_count != 8'd0)) begin
                    if (in_count == 8'd1) begin
                        dec_fill = 1'b1;
                    end else if (in_count < 8'(SEG_PIXELS)) begin
                        dec_write = (in_pix < in_count);
                    end else begin
                        // long list, clamped to the segment; downward runs reversed
                        dec_write = pix_ok;
                        if (in_down) begin
                            pix_sel = 8'(SEG_PIXELS - 1) - in_pix;
                        end
                    end
                end
            end
            FUNC_CLEAR, FUNC_SHOW: begin
                dec_write = 1'b0;
            end
        endcase
        dec_addr = dec_fill ? seg_base : (seg_base + AW'(pix_sel));
    end

    // read credit: queue entries plus the read in flight never exceed two
    assign pop       = m_tvalid && m_tready;
    assign occupancy = q_count + 2'(rd_pending_reg);
    assign issue     = (state_reg == ST_SHOW) && ((occupancy < 2'd2) || pop);

    // control and sweep registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_INIT;
            ptr_reg          <= '0;
            fill_cnt_reg     <= '0;
            do_write_reg     <= 1'b0;
            zero_reg         <= 1'b0;
            rd_pending_reg   <= 1'b0;
            last_pending_reg <= 1'b0;
            zero_pending_reg <= 1'b0;
        end else begin
            rd_pending_reg   <= issue;
            last_pending_reg <= issue && (ptr_reg == LAST_ADDR);
            zero_pending_reg <= zero_reg;
            unique case (state_reg)
                ST_INIT: begin
                    if (ptr_reg == LAST_ADDR) begin
                        ptr_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        ptr_reg <= ptr_reg + AW'(1);
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        do_write_reg <= dec_write;
                        fill_cnt_reg <= '0;
                        zero_reg     <= (in_func == FUNC_CLEAR);
                        ptr_reg      <= '0;
                        if ((in_func == FUNC_CLEAR) || (in_func == FUNC_SHOW)) begin
                            state_reg <= ST_SHOW;
                        end else begin
                            state_reg <= dec_fill ? ST_FILL : ST_SCALE;
                        end
                    end
                end
                ST_SCALE: begin
                    state_reg <= ST_WRITE;
                end
                ST_WRITE: begin
                    state_reg <= ST_IDLE;
                end
                ST_FILL: begin
                    // first fill cycle waits for the scaler like a single write
                    if (do_write_reg) begin
                        fill_cnt_reg <= fill_cnt_reg + PW'(1);
                        if (fill_cnt_reg == LAST_PIX) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    do_write_reg <= 1'b1;
                end
                ST_SHOW: begin
                    if (issue) begin
                        ptr_reg <= ptr_reg + AW'(1);
                        if (ptr_reg == LAST_ADDR) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // the segment base is held in wr_addr_reg during a fill
    always_ff @(posedge aclk) begin
        if (accept) begin
            wr_addr_reg <= dec_addr;
        end
    end

    // store write port: init pass, clear sweep, single write, fill
    always_comb begin
        st_wr_en   = 1'b0;
        st_wr_addr = wr_addr_reg;
        st_wr_data = scaled_rgb;
        unique case (state_reg)
            ST_INIT: begin
                st_wr_en   = 1'b1;
                st_wr_addr = ptr_reg;
                st_wr_data = '0;
            end
            ST_WRITE: begin
                st_wr_en = do_write_reg;
            end
            ST_FILL: begin
                st_wr_en   = do_write_reg;
                st_wr_addr = wr_addr_reg + AW'(fill_cnt_reg);
            end
            ST_SHOW: begin
                st_wr_en   = issue && zero_reg;
                st_wr_addr = ptr_reg;
                st_wr_data = '0;
            end
            default: begin
                st_wr_en = 1'b0;
            end
        endcase
    end

    spb_scale u_scale (
        .aclk       (aclk),
        .load       (accept),
        .rgb_color  (in_rgb),
        .brightness (in_bright),
        .scaled_rgb (scaled_rgb)
    );

    spb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (issue),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    // rgb store layout to grb strip word, low byte zero; the whole word is zero on clear-and-show
    always_comb begin
        if (zero_pending_reg) begin
            push_word.strip_word = '0;
        end else begin
            push_word.strip_word = {rd_data[15:8], rd_data[23:16], rd_data[7:0], 8'h00};
        end
        push_word.frame_last = last_pending_reg;
    end

    spb_ofifo u_ofifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rd_pending_reg),
        .push_word (push_word),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_word  (out_word),
        .count     (q_count)
    );

    assign m_tdata = out_word.strip_word;
    assign m_tlast = out_word.frame_last;

    // queue plus read in flight never overruns the two entries
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_count + 2'(rd_pending_reg)) <= 2'd2)
        else $error("output queue overrun");

    // the read of the last word of a frame ends the sweep
    assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_pending_reg && last_pending_reg) |-> (state_reg == ST_IDLE))
        else $error("frame sweep did not end on last word");

    // no store write can land while commands are being taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !st_wr_en)
        else $error("store write while idle");

endmodule

// File: design/spb_scale.sv
// brightness scaler: each 8-bit component times brightness, divided by 100
// two register stages; depends on spb_pkg
module spb_scale (
    input  logic                      aclk,
    input  logic                      load,
    input  logic [spb_pkg::RGB_W-1:0] rgb_color,
    input  logic [7:0]                brightness,
    output logic [spb_pkg::RGB_W-1:0] scaled_rgb
);
    import spb_pkg::*;

    // floor(p / 100) == (p * 83887) >> 23 for any 16-bit p
    localparam logic [16:0] RECIP_100   = 17'd83887;
    localparam int unsigned RECIP_SHIFT = 23;
    localparam int unsigned PROD_W      = 16;
    localparam int unsigned FULL_W      = PROD_W + 17;

    logic [PROD_W-1:0] prod_reg [3];
    logic [FULL_W-1:0] full     [3];
    logic [RGB_W-1:0]  scaled_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int k = 0; k < 3; k++) begin
                prod_reg[k] <= PROD_W'(rgb_color[8*k +: 8]) * PROD_W'(brightness);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            full[k] = FULL_W'(prod_reg[k]) * FULL_W'(RECIP_100);
        end
    end

    // keep only the low 8 bits of each quotient
    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            scaled_reg[8*k +: 8] <= full[k][RECIP_SHIFT +: 8];
        end
    end

    assign scaled_rgb = scaled_reg;

endmodule

// File: design/spb_store.sv
// pixel store: one write port, one read port with registered read data
// depends on spb_pkg
module spb_store #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [spb_pkg::RGB_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [spb_pkg::RGB_W-1:0] rd_data
);
    import spb_pkg::*;

    logic [RGB_W-1:0] mem [DEPTH];
    logic [RGB_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/spb_ofifo.sv
// two-entry output queue in front of the master channel
// depends on spb_pkg
module spb_ofifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  spb_pkg::out_word_t push_word,
    input  logic               pop,
    output logic               out_valid,
    output spb_pkg::out_word_t out_word,
    output logic [1:0]         count
);
    import spb_pkg::*;

    out_word_t  buf_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop) begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wptr_reg] <= push_word;
        end
    end

    assign out_valid = (cnt_reg != 2'd0);
    assign out_word  = buf_reg[rptr_reg];
    assign count     = cnt_reg;

endmodule
